// ===== design/mkm_pkg.sv =====
`timescale 1ns / 1ps

package mkm_pkg;

    // fixed field widths
    localparam int DIST_W     = 38;
    localparam int VAL_W      = 16;
    localparam int IDX_OUT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int ML_W       = 5;

    // operation codes
    localparam logic [1:0] OP_LOAD_SOURCE = 2'd0;
    localparam logic [1:0] OP_LOAD_TARGET = 2'd1;
    localparam logic [1:0] OP_QUERY       = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REV_SETUP,
        ST_CHECK,
        ST_FINISH
    } state_t;

endpackage

// ===== design/mkm_store.sv =====
`timescale 1ns / 1ps

module mkm_store #(
    parameter int DEPTH  = 33792,
    parameter int ADDR_W = 16
) (
    input  logic                        aclk,
    input  logic                        wen,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [mkm_pkg::VAL_W-1:0]   wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [mkm_pkg::VAL_W-1:0]   rdata
);

    logic [mkm_pkg::VAL_W-1:0] mem [DEPTH];
    logic [mkm_pkg::VAL_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mkm_dist.sv =====
`timescale 1ns / 1ps

module mkm_dist #(
    parameter int PT_W = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_v,
    input  logic                        in_last,
    input  logic [PT_W-1:0]             in_tag,
    input  logic [mkm_pkg::VAL_W-1:0]   a,
    input  logic [mkm_pkg::VAL_W-1:0]   b,
    output logic                        out_v,
    output logic [PT_W-1:0]             out_tag,
    output logic [mkm_pkg::DIST_W-1:0]  out_d,
    output logic                        busy
);

    logic [mkm_pkg::VAL_W-1:0]   absdiff;
    logic                        sq_v_reg;
    logic                        sq_last_reg;
    logic [PT_W-1:0]             sq_tag_reg;
    logic [2*mkm_pkg::VAL_W-1:0] sq_reg;
    logic [mkm_pkg::DIST_W-1:0]  acc_reg;
    logic [mkm_pkg::DIST_W-1:0]  sum;
    logic                        out_v_reg;
    logic [PT_W-1:0]             out_tag_reg;
    logic [mkm_pkg::DIST_W-1:0]  out_d_reg;

    assign absdiff = (a > b) ? (a - b) : (b - a);
    assign sum     = acc_reg + mkm_pkg::DIST_W'(sq_reg);

    // square stage and accumulate stage, control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            sq_v_reg  <= in_v;
            out_v_reg <= sq_v_reg && sq_last_reg;
            if (sq_v_reg) begin
                acc_reg <= sq_last_reg ? '0 : sum;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        sq_last_reg <= in_last;
        sq_tag_reg  <= in_tag;
        sq_reg      <= (2*mkm_pkg::VAL_W)'(absdiff) * (2*mkm_pkg::VAL_W)'(absdiff);
        if (sq_v_reg && sq_last_reg) begin
            out_d_reg   <= sum;
            out_tag_reg <= sq_tag_reg;
        end
    end

    assign out_v   = out_v_reg;
    assign out_tag = out_tag_reg;
    assign out_d   = out_d_reg;
    assign busy    = sq_v_reg || out_v_reg;

endmodule

// ===== design/mkm_list.sv =====
`timescale 1ns / 1ps

module mkm_list #(
    parameter int MAX_K = 16,
    parameter int PT_W  = 10,
    parameter int K_W   = 5,
    parameter int KI_W  = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        upd,
    input  logic [K_W-1:0]              size,
    input  logic [mkm_pkg::DIST_W-1:0]  d_in,
    input  logic [PT_W-1:0]             i_in,
    output logic [PT_W-1:0]             idx_o  [MAX_K],
    output logic [mkm_pkg::DIST_W-1:0]  dist_o [MAX_K]
);

    logic [PT_W-1:0]            idx_reg   [MAX_K];
    logic [PT_W-1:0]            idx_next  [MAX_K];
    logic [mkm_pkg::DIST_W-1:0] dist_reg  [MAX_K];
    logic [mkm_pkg::DIST_W-1:0] dist_next [MAX_K];
    logic [KI_W-1:0]            last_i;
    logic                       take;

    assign last_i = KI_W'(size - 1'b1);
    assign take   = upd && (d_in < dist_reg[last_i]);

    // sorted insert, equal distances keep the earlier index first
    always_comb begin
        int jp;
        for (int j = 0; j < MAX_K; j++) begin
            jp = (j == 0) ? 0 : j - 1;
            idx_next[j]  = idx_reg[j];
            dist_next[j] = dist_reg[j];
            if (clear) begin
                idx_next[j]  = '0;
                dist_next[j] = '1;
            end else if (take && (32'(j) < 32'(size))) begin
                if (dist_reg[j] > d_in) begin
                    if ((j == 0) || (dist_reg[jp] <= d_in)) begin
                        idx_next[j]  = i_in;
                        dist_next[j] = d_in;
                    end else begin
                        idx_next[j]  = idx_reg[jp];
                        dist_next[j] = dist_reg[jp];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_K; j++) begin
                idx_reg[j]  <= '0;
                dist_reg[j] <= '1;
            end
        end else begin
            idx_reg  <= idx_next;
            dist_reg <= dist_next;
        end
    end

    assign idx_o  = idx_reg;
    assign dist_o = dist_reg;

endmodule

// ===== design/mutual_knn_feature_matcher_unit.sv =====
`timescale 1ns / 1ps

// Mutual k-nearest-neighbor matcher over two descriptor memories (source and
// target, MAX_POINTS x BINS bins of 16 bits each). A query first scans all
// target descriptors against the queried source point, then for each of the
// n forward candidates, n = min(match_limit, MAX_K, target count), scans all
// source descriptors, one bin of each memory per cycle on its single read
// port. Only one query is in flight; the next item is taken when the results
// are all handed to the output register. Memory contents are undefined until
// loaded. A result waits on m_ready while the output register is full; a query
// with nothing to search goes straight to its not-found result.
module mutual_knn_feature_matcher_unit #(
    parameter int MAX_POINTS = 1024,
    parameter int BINS       = 33,
    parameter int MAX_K      = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [9:0]                          s_point_index,
    input  logic [5:0]                          s_bin_index,
    input  logic [15:0]                         s_bin_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [9:0]                          m_source_index,
    output logic [9:0]                          m_target_index,
    output logic [37:0]                         m_feature_distance,
    output logic                                m_found,
    output logic                                m_last_of_run,
    input  logic                                cfg_wen,
    input  logic [mkm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mkm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int PT_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int ADDR_W = $clog2(MAX_POINTS * BINS);
    localparam int BW     = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int K_W    = $clog2(MAX_K + 1);
    localparam int KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DW     = mkm_pkg::DIST_W;

    mkm_pkg::state_t state_reg, state_next;

    // configuration
    logic [mkm_pkg::ML_W-1:0]       ml_reg;
    logic [mkm_pkg::CFG_DATA_W-1:0] sc_cfg_reg;
    logic [mkm_pkg::CFG_DATA_W-1:0] tc_cfg_reg;

    // query control
    logic [9:0]        q_reg, q_next;
    logic [CNT_W-1:0]  sc_reg, sc_next;
    logic [K_W-1:0]    n_reg, n_next;
    logic [K_W-1:0]    nr_reg, nr_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [KI_W-1:0]   j_reg, j_next;
    logic              phase_rev_reg, phase_rev_next;
    logic [ADDR_W-1:0] probe_base_reg, probe_base_next;
    logic [ADDR_W-1:0] cand_base_reg, cand_base_next;
    logic [PT_W-1:0]   cand_reg, cand_next;
    logic [BW-1:0]     bin_reg, bin_next;
    logic              pend_v_reg, pend_v_next;
    logic [PT_W-1:0]   pend_t_reg, pend_t_next;
    logic [DW-1:0]     pend_d_reg, pend_d_next;

    // output register
    logic              m_valid_reg;
    logic [9:0]        m_src_reg;
    logic [9:0]        m_tgt_reg;
    logic [DW-1:0]     m_dist_reg;
    logic              m_found_reg;
    logic              m_last_reg;

    logic              push;
    logic [PT_W-1:0]   push_t;
    logic [DW-1:0]     push_d;
    logic              push_found;
    logic              push_last;
    logic              out_free;

    // read pipeline
    logic              rd_v_reg;
    logic              rd_last_reg;
    logic [PT_W-1:0]   rd_tag_reg;
    logic              issue_v;
    logic              issue_last;
    logic [ADDR_W-1:0] probe_addr;
    logic [ADDR_W-1:0] cand_addr;
    logic [ADDR_W-1:0] src_raddr;
    logic [ADDR_W-1:0] tgt_raddr;
    logic [ADDR_W-1:0] load_addr;
    logic              load_ok;
    logic              accept;
    logic [mkm_pkg::VAL_W-1:0] src_rdata;
    logic [mkm_pkg::VAL_W-1:0] tgt_rdata;

    logic              d_v;
    logic [PT_W-1:0]   d_tag;
    logic [DW-1:0]     d_val;
    logic              dist_busy;

    logic              fwd_clear;
    logic              rev_clear;
    logic [PT_W-1:0]   fwd_idx  [MAX_K];
    logic [DW-1:0]     fwd_dist [MAX_K];
    logic [PT_W-1:0]   rev_idx  [MAX_K];
    logic [DW-1:0]     rev_dist [MAX_K];

    logic [CNT_W-1:0]  sc_c;
    logic [CNT_W-1:0]  tc_c;
    logic [K_W-1:0]    k_c;
    logic [K_W-1:0]    n_c;
    logic [K_W-1:0]    nr_c;
    logic              keep;

    // clamped limits for a new query
    assign sc_c = (32'(sc_cfg_reg) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(sc_cfg_reg);
    assign tc_c = (32'(tc_cfg_reg) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(tc_cfg_reg);
    assign k_c  = (32'(ml_reg) > 32'(MAX_K)) ? K_W'(MAX_K) : K_W'(ml_reg);
    assign n_c  = (32'(k_c) < 32'(tc_c)) ? k_c : K_W'(tc_c);
    assign nr_c = (32'(n_c) < 32'(sc_c)) ? n_c : K_W'(sc_c);

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == mkm_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // load address and range check
    assign load_ok   = (32'(s_point_index) < 32'(MAX_POINTS)) && (32'(s_bin_index) < 32'(BINS));
    assign load_addr = ADDR_W'(PT_W'(s_point_index)) * ADDR_W'(BINS) + ADDR_W'(s_bin_index);

    // scan read addresses, the probe memory swaps with the phase
    assign issue_v    = (state_reg == mkm_pkg::ST_SCAN);
    assign issue_last = (bin_reg == BW'(BINS - 1));
    assign probe_addr = probe_base_reg + ADDR_W'(bin_reg);
    assign cand_addr  = cand_base_reg + ADDR_W'(bin_reg);
    assign src_raddr  = phase_rev_reg ? cand_addr : probe_addr;
    assign tgt_raddr  = phase_rev_reg ? probe_addr : cand_addr;

    mkm_store #(.DEPTH(MAX_POINTS * BINS), .ADDR_W(ADDR_W)) u_src_store (
        .aclk  (aclk),
        .wen   (accept && load_ok && (s_operation == mkm_pkg::OP_LOAD_SOURCE)),
        .waddr (load_addr),
        .wdata (s_bin_value),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    mkm_store #(.DEPTH(MAX_POINTS * BINS), .ADDR_W(ADDR_W)) u_tgt_store (
        .aclk  (aclk),
        .wen   (accept && load_ok && (s_operation == mkm_pkg::OP_LOAD_TARGET)),
        .waddr (load_addr),
        .wdata (s_bin_value),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    mkm_dist #(.PT_W(PT_W)) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_v    (rd_v_reg),
        .in_last (rd_last_reg),
        .in_tag  (rd_tag_reg),
        .a       (src_rdata),
        .b       (tgt_rdata),
        .out_v   (d_v),
        .out_tag (d_tag),
        .out_d   (d_val),
        .busy    (dist_busy)
    );

    mkm_list #(.MAX_K(MAX_K), .PT_W(PT_W), .K_W(K_W), .KI_W(KI_W)) u_fwd_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (fwd_clear),
        .upd     (d_v && !phase_rev_reg),
        .size    (n_reg),
        .d_in    (d_val),
        .i_in    (d_tag),
        .idx_o   (fwd_idx),
        .dist_o  (fwd_dist)
    );

    mkm_list #(.MAX_K(MAX_K), .PT_W(PT_W), .K_W(K_W), .KI_W(KI_W)) u_rev_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (rev_clear),
        .upd     (d_v && phase_rev_reg),
        .size    (nr_reg),
        .d_in    (d_val),
        .i_in    (d_tag),
        .idx_o   (rev_idx),
        .dist_o  (rev_dist)
    );

    // queried point among the reverse neighbors
    always_comb begin
        keep = 1'b0;
        for (int r = 0; r < MAX_K; r++) begin
            if ((32'(r) < 32'(nr_reg)) && (32'(rev_idx[r]) == 32'(q_reg))) begin
                keep = 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        q_next          = q_reg;
        sc_next         = sc_reg;
        n_next          = n_reg;
        nr_next         = nr_reg;
        scan_cnt_next   = scan_cnt_reg;
        j_next          = j_reg;
        phase_rev_next  = phase_rev_reg;
        probe_base_next = probe_base_reg;
        cand_base_next  = cand_base_reg;
        cand_next       = cand_reg;
        bin_next        = bin_reg;
        pend_v_next     = pend_v_reg;
        pend_t_next     = pend_t_reg;
        pend_d_next     = pend_d_reg;
        fwd_clear       = 1'b0;
        rev_clear       = 1'b0;
        push            = 1'b0;
        push_t          = pend_t_reg;
        push_d          = pend_d_reg;
        push_found      = 1'b1;
        push_last       = 1'b0;
        case (state_reg)
            mkm_pkg::ST_IDLE: begin
                if (s_valid && (s_operation == mkm_pkg::OP_QUERY)) begin
                    q_next          = s_point_index;
                    sc_next         = sc_c;
                    n_next          = n_c;
                    nr_next         = nr_c;
                    scan_cnt_next   = tc_c;
                    phase_rev_next  = 1'b0;
                    probe_base_next = ADDR_W'(PT_W'(s_point_index)) * ADDR_W'(BINS);
                    cand_base_next  = '0;
                    cand_next       = '0;
                    bin_next        = '0;
                    pend_v_next     = 1'b0;
                    fwd_clear       = 1'b1;
                    if ((n_c == '0) || !(32'(s_point_index) < 32'(sc_c))) begin
                        state_next = mkm_pkg::ST_FINISH;
                    end else begin
                        state_next = mkm_pkg::ST_SCAN;
                    end
                end
            end
            mkm_pkg::ST_SCAN: begin
                if (issue_last) begin
                    bin_next       = '0;
                    cand_next      = cand_reg + 1'b1;
                    cand_base_next = cand_base_reg + ADDR_W'(BINS);
                    if (cand_reg == PT_W'(scan_cnt_reg - 1'b1)) begin
                        state_next = mkm_pkg::ST_DRAIN;
                    end
                end else begin
                    bin_next = bin_reg + 1'b1;
                end
            end
            mkm_pkg::ST_DRAIN: begin
                if (!rd_v_reg && !dist_busy) begin
                    if (!phase_rev_reg) begin
                        j_next     = '0;
                        state_next = mkm_pkg::ST_REV_SETUP;
                    end else begin
                        state_next = mkm_pkg::ST_CHECK;
                    end
                end
            end
            mkm_pkg::ST_REV_SETUP: begin
                probe_base_next = ADDR_W'(fwd_idx[j_reg]) * ADDR_W'(BINS);
                cand_base_next  = '0;
                cand_next       = '0;
                bin_next        = '0;
                phase_rev_next  = 1'b1;
                scan_cnt_next   = sc_reg;
                rev_clear       = 1'b1;
                state_next      = mkm_pkg::ST_SCAN;
            end
            mkm_pkg::ST_CHECK: begin
                if (!keep || !pend_v_reg || out_free) begin
                    if (keep) begin
                        push        = pend_v_reg;
                        pend_v_next = 1'b1;
                        pend_t_next = fwd_idx[j_reg];
                        pend_d_next = fwd_dist[j_reg];
                    end
                    if (32'(j_reg) == 32'(n_reg) - 1) begin
                        state_next = mkm_pkg::ST_FINISH;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = mkm_pkg::ST_REV_SETUP;
                    end
                end
            end
            mkm_pkg::ST_FINISH: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (!pend_v_reg) begin
                        push_t     = '0;
                        push_d     = '0;
                        push_found = 1'b0;
                    end
                    state_next = mkm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mkm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mkm_pkg::ST_IDLE;
            ml_reg        <= mkm_pkg::ML_W'(5);
            sc_cfg_reg    <= mkm_pkg::CFG_DATA_W'(1024);
            tc_cfg_reg    <= mkm_pkg::CFG_DATA_W'(1024);
            rd_v_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            pend_v_reg    <= 1'b0;
            phase_rev_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_v_reg      <= issue_v;
            pend_v_reg    <= pend_v_next;
            phase_rev_reg <= phase_rev_next;
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wen) begin
                case (cfg_index)
                    mkm_pkg::CFG_MATCH_LIMIT:  ml_reg     <= mkm_pkg::ML_W'(cfg_wdata);
                    mkm_pkg::CFG_SOURCE_COUNT: sc_cfg_reg <= cfg_wdata;
                    mkm_pkg::CFG_TARGET_COUNT: tc_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        q_reg          <= q_next;
        sc_reg         <= sc_next;
        n_reg          <= n_next;
        nr_reg         <= nr_next;
        scan_cnt_reg   <= scan_cnt_next;
        j_reg          <= j_next;
        probe_base_reg <= probe_base_next;
        cand_base_reg  <= cand_base_next;
        cand_reg       <= cand_next;
        bin_reg        <= bin_next;
        pend_t_reg     <= pend_t_next;
        pend_d_reg     <= pend_d_next;
        rd_last_reg    <= issue_last;
        rd_tag_reg     <= cand_reg;
        if (push) begin
            m_src_reg   <= q_reg;
            m_tgt_reg   <= 10'(push_t);
            m_dist_reg  <= push_d;
            m_found_reg <= push_found;
            m_last_reg  <= push_last;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_source_index     = m_src_reg;
    assign m_target_index     = m_tgt_reg;
    assign m_feature_distance = m_dist_reg;
    assign m_found            = m_found_reg;
    assign m_last_of_run      = m_last_reg;

    // the read pipeline is empty whenever new items are taken
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mkm_pkg::ST_IDLE) |-> (!rd_v_reg && !dist_busy))
        else $error("read pipeline busy while idle");

    // memory reads only come from the scan state
    a_read_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_v_reg |-> $past(state_reg == mkm_pkg::ST_SCAN))
        else $error("read issued outside a scan");

    // a not-found transaction always closes the run
    a_notfound_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> m_last_of_run)
        else $error("not-found transaction without last flag");

    // a push never overwrites a transaction still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("output register overwritten");

endmodule

// ===== tb/mutual_knn_feature_matcher_unit_tb.sv =====
`timescale 1ns / 1ps

module mutual_knn_feature_matcher_unit_tb;

    localparam int NPTS = 1024;
    localparam int NBIN = 33;
    localparam int KMAX = 16;
    localparam logic [mkm_pkg::DIST_W-1:0] FAR = '1;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [9:0]  pt;
        logic [5:0]  bin;
        logic [15:0] val;
    } feat_cmd_t;

    typedef struct {
        logic [9:0]                 src;
        logic [9:0]                 tgt;
        logic [mkm_pkg::DIST_W-1:0] fdist;
        logic                       found;
        logic                       last;
    } match_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_operation;
    logic [9:0] s_point_index;
    logic [5:0] s_bin_index;
    logic [15:0] s_bin_value;
    logic m_valid;
    logic m_ready;
    logic [9:0] m_source_index;
    logic [9:0] m_target_index;
    logic [37:0] m_feature_distance;
    logic m_found;
    logic m_last_of_run;
    logic cfg_wen;
    logic [mkm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mkm_pkg::CFG_DATA_W-1:0] cfg_wdata;

    mutual_knn_feature_matcher_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_point_index(s_point_index),
        .s_bin_index(s_bin_index), .s_bin_value(s_bin_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_source_index(m_source_index), .m_target_index(m_target_index),
        .m_feature_distance(m_feature_distance), .m_found(m_found),
        .m_last_of_run(m_last_of_run),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // descriptor mirror and register copy
    logic [15:0] src_desc [NPTS][NBIN];
    logic [15:0] tgt_desc [NPTS][NBIN];
    int unsigned lim_reg;
    int unsigned src_cnt_reg;
    int unsigned tgt_cnt_reg;

    // search lists
    logic [9:0]                 fwd_idx  [KMAX];
    logic [mkm_pkg::DIST_W-1:0] fwd_dist [KMAX];
    logic [9:0]                 rev_idx  [KMAX];
    logic [mkm_pkg::DIST_W-1:0] rev_dist [KMAX];

    feat_cmd_t pending_cmds[$];
    match_t    expected_matches[$];
    int        mismatches;
    bit        took;
    bit        calm;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [mkm_pkg::DIST_W-1:0] pair_dist(int s, int t);
        logic [mkm_pkg::DIST_W-1:0] acc;
        longint d;
        acc = '0;
        for (int b = 0; b < NBIN; b++) begin
            d = longint'(src_desc[s][b]) - longint'(tgt_desc[t][b]);
            acc += mkm_pkg::DIST_W'(d * d);
        end
        return acc;
    endfunction

    // nearest targets of source s (fwd) or nearest sources of target t (rev)
    function automatic void nearest(bit reverse, int probe, int count, int k);
        logic [mkm_pkg::DIST_W-1:0] d;
        int j;
        for (j = 0; j < KMAX; j++) begin
            if (reverse) begin
                rev_idx[j] = '0; rev_dist[j] = FAR;
            end else begin
                fwd_idx[j] = '0; fwd_dist[j] = FAR;
            end
        end
        for (int p = 0; p < count; p++) begin
            d = reverse ? pair_dist(p, probe) : pair_dist(probe, p);
            if (reverse) begin
                if (k == 0 || d >= rev_dist[k-1]) continue;
                j = k - 1;
                while (j > 0 && rev_dist[j-1] > d) begin
                    rev_dist[j] = rev_dist[j-1]; rev_idx[j] = rev_idx[j-1]; j--;
                end
                rev_dist[j] = d; rev_idx[j] = 10'(p);
            end else begin
                if (k == 0 || d >= fwd_dist[k-1]) continue;
                j = k - 1;
                while (j > 0 && fwd_dist[j-1] > d) begin
                    fwd_dist[j] = fwd_dist[j-1]; fwd_idx[j] = fwd_idx[j-1]; j--;
                end
                fwd_dist[j] = d; fwd_idx[j] = 10'(p);
            end
        end
    endfunction

    // apply one accepted transaction to the mirror, queue its matches
    function automatic void predict_matches(feat_cmd_t c);
        int sc, tc, k, n, nr, kept;
        bit keep;
        match_t m;
        if (c.op == mkm_pkg::OP_LOAD_SOURCE || c.op == mkm_pkg::OP_LOAD_TARGET) begin
            if (c.bin < NBIN) begin
                if (c.op == mkm_pkg::OP_LOAD_SOURCE) src_desc[c.pt][c.bin] = c.val;
                else tgt_desc[c.pt][c.bin] = c.val;
            end
            return;
        end
        if (c.op != mkm_pkg::OP_QUERY) return;
        sc = (src_cnt_reg > NPTS) ? NPTS : src_cnt_reg;
        tc = (tgt_cnt_reg > NPTS) ? NPTS : tgt_cnt_reg;
        k  = (lim_reg > KMAX) ? KMAX : lim_reg;
        n  = (k < tc) ? k : tc;
        nr = (n < sc) ? n : sc;
        kept = 0;
        if (n > 0 && c.pt < sc) begin
            nearest(1'b0, c.pt, tc, n);
            for (int j = 0; j < n; j++) begin
                nearest(1'b1, fwd_idx[j], sc, nr);
                keep = 1'b0;
                for (int r = 0; r < nr; r++) if (rev_idx[r] == c.pt) keep = 1'b1;
                if (keep) begin
                    m.src = c.pt; m.tgt = fwd_idx[j]; m.fdist = fwd_dist[j];
                    m.found = 1'b1; m.last = 1'b0;
                    expected_matches = {expected_matches, m};
                    kept++;
                end
            end
        end
        if (kept == 0) begin
            m.src = c.pt; m.tgt = '0; m.fdist = '0; m.found = 1'b0; m.last = 1'b1;
            expected_matches = {expected_matches, m};
        end else begin
            expected_matches[$].last = 1'b1;
        end
    endfunction

    // acceptance of input transactions
    always @(posedge aclk) begin
        feat_cmd_t c;
        if (aresetn && s_valid && s_ready) begin
            c.op = s_operation; c.pt = s_point_index;
            c.bin = s_bin_index; c.val = s_bin_value;
            predict_matches(c);
            took = 1'b1;
        end
    end

    // driver
    always @(negedge aclk) begin
        feat_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || took) begin
            took = 1'b0;
            if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
                c = pending_cmds.pop_front();
                s_valid       <= 1'b1;
                s_operation   <= c.op;
                s_point_index <= c.pt;
                s_bin_index   <= c.bin;
                s_bin_value   <= c.val;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 11);
    end

    // monitor
    always @(posedge aclk) begin
        match_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: src %0d tgt %0d dist %0d found %0b last %0b",
                             m_source_index, m_target_index, m_feature_distance,
                             m_found, m_last_of_run);
            end else begin
                e = expected_matches.pop_front();
                if (m_source_index !== e.src || m_target_index !== e.tgt ||
                    m_feature_distance !== e.fdist || m_found !== e.found ||
                    m_last_of_run !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp src %0d tgt %0d dist %0d found %0b last %0b,",
                                  " got src %0d tgt %0d dist %0d found %0b last %0b"},
                                 e.src, e.tgt, e.fdist, e.found, e.last,
                                 m_source_index, m_target_index, m_feature_distance,
                                 m_found, m_last_of_run);
                end
            end
        end
    end

    task automatic push_cmd(logic [1:0] op, int pt, int bin, int val);
        feat_cmd_t c;
        c.op = op; c.pt = 10'(pt); c.bin = 6'(bin); c.val = 16'(val);
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || expected_matches.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [mkm_pkg::CFG_IDX_W-1:0] idx, int val);
        @(negedge aclk);
        cfg_wen <= 1'b1; cfg_index <= idx; cfg_wdata <= mkm_pkg::CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_wen <= 1'b0;
        if (idx == mkm_pkg::CFG_MATCH_LIMIT) lim_reg = val & 'h1f;
        else if (idx == mkm_pkg::CFG_SOURCE_COUNT) src_cnt_reg = val & 'h7ff;
        else if (idx == mkm_pkg::CFG_TARGET_COUNT) tgt_cnt_reg = val & 'h7ff;
    endtask

    task automatic set_regs(int ml, int sc, int tc);
        wait_drained();
        write_reg(mkm_pkg::CFG_MATCH_LIMIT, ml);
        write_reg(mkm_pkg::CFG_SOURCE_COUNT, sc);
        write_reg(mkm_pkg::CFG_TARGET_COUNT, tc);
    endtask

    // stimulus
    initial begin
        int base;
        int ml, sc, tc, pt;
        s_valid = 1'b0; s_operation = '0; s_point_index = '0;
        s_bin_index = '0; s_bin_value = '0; m_ready = 1'b0;
        cfg_wen = 1'b0; cfg_index = '0; cfg_wdata = '0;
        took = 1'b0; calm = 1'b0; mismatches = 0;
        lim_reg = 5; src_cnt_reg = 1024; tgt_cnt_reg = 1024;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // two sources close together, target 0 between them but nearer
        // source 1, target 1 far from both
        for (int b = 0; b < NBIN; b++) begin
            base = $urandom_range(0, 30000);
            push_cmd(mkm_pkg::OP_LOAD_SOURCE, 0, b, base);
            push_cmd(mkm_pkg::OP_LOAD_SOURCE, 1, b, base + 100);
            push_cmd(mkm_pkg::OP_LOAD_TARGET, 0, b, base + 90);
            push_cmd(mkm_pkg::OP_LOAD_TARGET, 1, b, base + 5000 + $urandom_range(0, 30000));
        end

        // directed: ignored items, rejection, several matches, empty searches
        push_cmd(mkm_pkg::OP_LOAD_SOURCE, 3, 33, 16'hffff);
        push_cmd(mkm_pkg::OP_LOAD_TARGET, 1023, 63, 16'hffff);
        push_cmd(OP_UNUSED, 1023, 63, 16'hffff);
        set_regs(1, 2, 2);
        push_cmd(mkm_pkg::OP_QUERY, 0, 0, 0);
        push_cmd(mkm_pkg::OP_QUERY, 1, 0, 0);
        push_cmd(mkm_pkg::OP_QUERY, 5, 0, 0);
        set_regs(2, 2, 2);
        push_cmd(mkm_pkg::OP_QUERY, 0, 0, 0);
        push_cmd(mkm_pkg::OP_QUERY, 1, 0, 0);
        set_regs(31, 2, 2);
        push_cmd(mkm_pkg::OP_QUERY, 0, 0, 0);
        set_regs(0, 2, 2);
        push_cmd(mkm_pkg::OP_QUERY, 1, 0, 0);
        set_regs(3, 0, 2);
        push_cmd(mkm_pkg::OP_QUERY, 0, 0, 0);
        set_regs(3, 2, 0);
        push_cmd(mkm_pkg::OP_QUERY, 0, 0, 0);
        set_regs(16, 1, 2);
        push_cmd(mkm_pkg::OP_QUERY, 0, 0, 0);

        // random phases: counts within the loaded points, bin reloads, queries
        for (int ph = 0; ph < 3; ph++) begin
            ml = $urandom_range(1, 16);
            sc = $urandom_range(1, 2);
            tc = $urandom_range(1, 2);
            set_regs(ml, sc, tc);
            calm = (ph == 1);
            for (int i = 0; i < 4; i++) begin
                pt = $urandom_range(0, 99) < 80 ? $urandom_range(0, sc - 1)
                                                : $urandom_range(0, 1023);
                case ($urandom_range(0, 9))
                    0, 1: push_cmd(mkm_pkg::OP_LOAD_SOURCE, $urandom_range(0, 1),
                                   $urandom_range(0, 32), $urandom);
                    2, 3: push_cmd(mkm_pkg::OP_LOAD_TARGET, $urandom_range(0, 1),
                                   $urandom_range(0, 32), $urandom);
                    4:    push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 1),
                                   $urandom_range(0, 63), $urandom);
                    default: push_cmd(mkm_pkg::OP_QUERY, pt, $urandom_range(0, 63), $urandom);
                endcase
                if (ph == 2 && i == 1) wait_drained();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== mutual_knn_feature_matcher_unit.f =====
design/mkm_pkg.sv
design/mkm_store.sv
design/mkm_dist.sv
design/mkm_list.sv
design/mutual_knn_feature_matcher_unit.sv
tb/mutual_knn_feature_matcher_unit_tb.sv
